// ===== sv/lsoc_pkg.sv =====
// ---------------------------------------------------------------------------
// lsoc_pkg: shared types and constants for the lidar sector classifier
// Beat formats, register indexes, reaction codes and controller links.
// ---------------------------------------------------------------------------
package lsoc_pkg;

  // Distance width of the scan points and of the sector minima
  localparam int DIST_W = 16;
  localparam int ANG_W  = 9;

  // Value a sector minimum holds while no point has landed in it,
  // saturated to the largest range when 9999 does not fit
  localparam logic [DIST_W-1:0] MIN_INIT = (DIST_W >= 14) ? DIST_W'(9999) : {DIST_W{1'b1}};

  // Sector edges in degrees
  localparam logic signed [ANG_W-1:0] ANG_LEFT_LO  = -9'sd60;
  localparam logic signed [ANG_W-1:0] ANG_FRONT_LO = -9'sd20;
  localparam logic signed [ANG_W-1:0] ANG_FRONT_HI = 9'sd20;
  localparam logic signed [ANG_W-1:0] ANG_RIGHT_HI = 9'sd60;

  // Severity arithmetic
  localparam int NUM_W     = DIST_W + 9;    // 400 times the largest range fits here
  localparam int SEV_W     = 10;
  localparam int DIV_STEPS = NUM_W;
  localparam int CNT_W     = $clog2(DIV_STEPS);
  localparam logic [8:0]       STOP_SPAN  = 9'd300;
  localparam logic [8:0]       WARN_SPAN  = 9'd400;
  localparam logic [SEV_W-1:0] STOP_BASE  = 10'd700;
  localparam logic [SEV_W-1:0] WARN_BASE  = 10'd300;
  localparam logic [SEV_W-1:0] SEV_FULL   = 10'd1000;
  localparam logic [SEV_W-1:0] SEV_ANGRY  = 10'd800;
  localparam logic [SEV_W-1:0] SEV_SUSPECT = 10'd500;

  // Configuration register indexes
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_WARN     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_STOP     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CRITICAL = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ENABLE   = 2'd3;

  // Action codes
  localparam logic [2:0] ACT_NONE   = 3'd0;
  localparam logic [2:0] ACT_SLOW   = 3'd1;
  localparam logic [2:0] ACT_STOP   = 3'd2;
  localparam logic [2:0] ACT_BACKUP = 3'd3;
  localparam logic [2:0] ACT_RIGHT  = 3'd4;
  localparam logic [2:0] ACT_LEFT   = 3'd5;

  // Side codes
  localparam logic [1:0] SIDE_NONE  = 2'd0;
  localparam logic [1:0] SIDE_FRONT = 2'd1;
  localparam logic [1:0] SIDE_LEFT  = 2'd2;
  localparam logic [1:0] SIDE_RIGHT = 2'd3;

  // Mood codes
  localparam logic [1:0] MOOD_NEUTRAL    = 2'd0;
  localparam logic [1:0] MOOD_SUSPICIOUS = 2'd1;
  localparam logic [1:0] MOOD_ANGRY      = 2'd2;

  typedef struct packed {
    logic signed [ANG_W-1:0] point_angle;
    logic [DIST_W-1:0]       point_distance;
    logic                    scanner_running;
    logic                    last_point;
  } in_item_t;

  typedef struct packed {
    logic              obstacle_found;
    logic [DIST_W-1:0] nearest_distance;
    logic [SEV_W-1:0]  severity_permille;
    logic [2:0]        action_code;
    logic [1:0]        side_code;
    logic [1:0]        mood_code;
  } out_item_t;

  // Controller to datapath
  typedef struct packed {
    logic latch_in;   // capture the accepted input beat
    logic fold;       // fold the held point into the sector minima
    logic eval;       // pick nearest sector, clear minima
    logic prep;       // form numerator and divisor
    logic div_step;   // one restoring division step
    logic load_out;   // write the reaction into the output register
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic item_last;  // held beat closes a scan
    logic need_div;   // reaction needs the banded severity divide
    logic out_free;   // output register can take a beat this cycle
  } stat_t;

endpackage

// ===== sv/lidar_sector_obstacle_classifier.sv =====
// ---------------------------------------------------------------------------
// lidar_sector_obstacle_classifier: top level
// Sequencing: a point is captured, then folded into the sector minima; a
// last point then goes through evaluation, preparation, the 25-step
// restoring divider when the banded severity needs it, and the output load.
// A new point is taken only when the previous one is fully handled, and after
// a last point only once its reaction beat has entered the output register.
// Reset: synchronous, clears minima to 9999 and loads register defaults.
// ---------------------------------------------------------------------------
module lidar_sector_obstacle_classifier
  import lsoc_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [DIST_W-1:0]    cfg_data,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  in_item_t             in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output out_item_t            out_data
);

  cmd_t  cmd;
  stat_t stat;

  // Sequencing controller
  lsoc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // Datapath
  lsoc_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_data   (in_data),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

// ===== sv/lsoc_ctrl.sv =====
// ---------------------------------------------------------------------------
// lsoc_ctrl: sequencing controller
// Steps each point through fold, and each last point through evaluation,
// preparation, the iterative severity divide when needed and the output load.
// ---------------------------------------------------------------------------
module lsoc_ctrl
  import lsoc_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  output logic  in_ready,
  input  stat_t stat,
  output cmd_t  cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_FOLD,
    S_EVAL,
    S_PREP,
    S_DIV,
    S_DONE
  } state_t;

  state_t           state;
  logic [CNT_W-1:0] div_cnt;

  // Decode commands from the current state
  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready     = 1'b1;
        cmd.latch_in = in_valid;
      end
      S_FOLD: cmd.fold     = 1'b1;
      S_EVAL: cmd.eval     = 1'b1;
      S_PREP: cmd.prep     = 1'b1;
      S_DIV:  cmd.div_step = 1'b1;
      S_DONE: cmd.load_out = stat.out_free;
      default: cmd = '0;
    endcase
  end

  // Advance state and the division step counter
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      div_cnt <= '0;
    end else begin
      unique case (state)
        S_IDLE: if (in_valid) state <= S_FOLD;
        S_FOLD: state <= stat.item_last ? S_EVAL : S_IDLE;
        S_EVAL: state <= S_PREP;
        S_PREP: begin
          div_cnt <= '0;
          state   <= stat.need_div ? S_DIV : S_DONE;
        end
        S_DIV: begin
          div_cnt <= div_cnt + CNT_W'(1);
          if (div_cnt == CNT_W'(DIV_STEPS - 1)) state <= S_DONE;
        end
        S_DONE: if (stat.out_free) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  // Counter never runs past the last division step
  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV) |-> (div_cnt <= CNT_W'(DIV_STEPS - 1)))
    else $error("division step counter overran");

  // Evaluation is always followed by preparation
  a_load_after_eval: assert property (@(posedge clk) disable iff (rst)
    cmd.eval |=> cmd.prep)
    else $error("evaluation not followed by preparation");

  // No input beat is taken while a reaction is in flight
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (cmd.div_step || cmd.prep) |-> !in_ready)
    else $error("input accepted during reaction");

endmodule

// ===== sv/lsoc_dp.sv =====
// ---------------------------------------------------------------------------
// lsoc_dp: classifier datapath
// Holds configuration, sector minima, the restoring divider and the
// output register for one reaction beat.
// ---------------------------------------------------------------------------
module lsoc_dp
  import lsoc_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [DIST_W-1:0]    cfg_data,
  input  in_item_t             in_data,
  input  cmd_t                 cmd,
  output stat_t                stat,
  output logic                 out_valid,
  input  logic                 out_ready,
  output out_item_t            out_data
);

  // Configuration
  logic [DIST_W-1:0] warn_mm, stop_mm, crit_mm;
  logic              avoid_enable;

  // Held input beat and sector minima
  in_item_t          item;
  logic [DIST_W-1:0] sec_left, sec_front, sec_right;

  // Evaluation results
  logic              res_hit, res_crit, res_stop;
  logic [DIST_W-1:0] res_c;
  logic [2:0]        res_act;
  logic [1:0]        res_side;

  // Divider
  logic [SEV_W-1:0]  base;
  logic [DIST_W-1:0] divisor;
  logic [NUM_W-1:0]  quo;
  logic [DIST_W-1:0] rem;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      warn_mm      <= DIST_W'(500);
      stop_mm      <= DIST_W'(300);
      crit_mm      <= DIST_W'(150);
      avoid_enable <= 1'b1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_WARN:     warn_mm      <= cfg_data;
        REG_STOP:     stop_mm      <= cfg_data;
        REG_CRITICAL: crit_mm      <= cfg_data;
        REG_ENABLE:   avoid_enable <= cfg_data[0];
        default:      ;
      endcase
    end
  end

  // Sector membership of the held point
  logic in_left, in_front, in_right, pt_valid;
  always_comb begin
    pt_valid = item.point_distance != '0;
    in_left  = (item.point_angle >= ANG_LEFT_LO) && (item.point_angle < ANG_FRONT_LO);
    in_front = (item.point_angle >= ANG_FRONT_LO) && (item.point_angle <= ANG_FRONT_HI);
    in_right = (item.point_angle > ANG_FRONT_HI) && (item.point_angle <= ANG_RIGHT_HI);
  end

  // Nearest of the three sector minima
  logic [DIST_W-1:0] near_c;
  always_comb begin
    near_c = sec_left;
    if (sec_front < near_c) near_c = sec_front;
    if (sec_right < near_c) near_c = sec_right;
  end

  // Hold the input beat, fold it, evaluate and clear minima
  always_ff @(posedge clk) begin
    if (rst) begin
      sec_left  <= MIN_INIT;
      sec_front <= MIN_INIT;
      sec_right <= MIN_INIT;
    end else begin
      if (cmd.fold && pt_valid) begin
        if (in_left && item.point_distance < sec_left) sec_left <= item.point_distance;
        if (in_front && item.point_distance < sec_front) sec_front <= item.point_distance;
        if (in_right && item.point_distance < sec_right) sec_right <= item.point_distance;
      end
      if (cmd.eval) begin
        sec_left  <= MIN_INIT;
        sec_front <= MIN_INIT;
        sec_right <= MIN_INIT;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch_in) item <= in_data;
    if (cmd.eval) begin
      res_c    <= near_c;
      res_hit  <= avoid_enable && item.scanner_running && (near_c < warn_mm);
      res_crit <= near_c <= crit_mm;
      res_stop <= near_c <= stop_mm;
      if (sec_front == near_c) begin
        res_side <= SIDE_FRONT;
        if (near_c <= crit_mm)      res_act <= ACT_BACKUP;
        else if (near_c <= stop_mm) res_act <= ACT_STOP;
        else                        res_act <= ACT_SLOW;
      end else if (sec_left < sec_right) begin
        res_side <= SIDE_LEFT;
        res_act  <= ACT_RIGHT;
      end else begin
        res_side <= SIDE_RIGHT;
        res_act  <= ACT_LEFT;
      end
    end
  end

  // Form numerator, divisor and base, then divide one bit per step
  logic [DIST_W-1:0] span_diff;
  logic [DIST_W:0]   rem_sh;
  logic [DIST_W:0]   rem_diff;
  always_comb begin
    span_diff = res_stop ? (stop_mm - res_c) : (warn_mm - res_c);
    rem_sh    = {rem, quo[NUM_W-1]};
    rem_diff  = rem_sh - {1'b0, divisor};
  end

  always_ff @(posedge clk) begin
    if (cmd.prep) begin
      quo     <= NUM_W'(span_diff) * NUM_W'(res_stop ? STOP_SPAN : WARN_SPAN);
      divisor <= res_stop ? (stop_mm - crit_mm) : (warn_mm - stop_mm);
      base    <= res_stop ? STOP_BASE : WARN_BASE;
      rem     <= '0;
    end else if (cmd.div_step) begin
      if (rem_sh >= {1'b0, divisor}) begin
        rem <= rem_diff[DIST_W-1:0];
        quo <= {quo[NUM_W-2:0], 1'b1};
      end else begin
        rem <= rem_sh[DIST_W-1:0];
        quo <= {quo[NUM_W-2:0], 1'b0};
      end
    end
  end

  // Severity, mood and the reaction beat
  logic [SEV_W:0]   sev_sum;
  logic [SEV_W-1:0] sev;
  out_item_t        result;
  always_comb begin
    sev_sum = {1'b0, base} + {1'b0, quo[SEV_W-1:0]};
    if (res_crit || quo > NUM_W'(SEV_FULL) || sev_sum > {1'b0, SEV_FULL}) sev = SEV_FULL;
    else sev = sev_sum[SEV_W-1:0];
    result = '0;
    if (res_hit) begin
      result.obstacle_found    = 1'b1;
      result.nearest_distance  = res_c;
      result.severity_permille = sev;
      result.action_code       = res_act;
      result.side_code         = res_side;
      if (sev >= SEV_ANGRY)        result.mood_code = MOOD_ANGRY;
      else if (sev >= SEV_SUSPECT) result.mood_code = MOOD_SUSPICIOUS;
      else                         result.mood_code = MOOD_NEUTRAL;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) out_data <= result;
  end

  always_comb begin
    stat.item_last = item.last_point;
    stat.need_div  = res_hit && !res_crit;
    stat.out_free  = !out_valid || out_ready;
  end

  // A beat without an obstacle carries all zero fields
  a_zero_beat: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_data.obstacle_found) |-> (out_data == '0))
    else $error("no-obstacle beat carries nonzero fields");

  // Severity stays in range and mood follows it
  a_sev_mood: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_data.severity_permille <= SEV_FULL) &&
      ((out_data.mood_code == MOOD_ANGRY) == (out_data.severity_permille >= SEV_ANGRY)))
    else $error("severity or mood out of step");

  // A front obstacle gives one of the forward actions
  a_front_act: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.side_code == SIDE_FRONT) |->
      (out_data.action_code == ACT_SLOW || out_data.action_code == ACT_STOP ||
       out_data.action_code == ACT_BACKUP))
    else $error("front side with turning action");

endmodule

// ===== tb/lsoc_reaction_checker.sv =====
// ---------------------------------------------------------------------------
// lsoc_reaction_checker: scoreboard for the lidar sector classifier
// Watches the register port and both channels, keeps its own sector minima
// and thresholds, predicts the reaction of every closed scan and compares
// each returned beat with the oldest prediction, field by field.
// ---------------------------------------------------------------------------
module lsoc_reaction_checker
  import lsoc_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [DIST_W-1:0]    cfg_data,
  input  logic                 in_valid,
  input  logic                 in_ready,
  input  in_item_t             in_data,
  input  logic                 out_valid,
  input  logic                 out_ready,
  input  out_item_t            out_data,
  output int                   fail_count,
  output int                   pending,
  output int                   reactions_checked,
  output int                   obstacles_checked
);

  // Shadow copy of the registers
  logic [DIST_W-1:0] thr_warn;
  logic [DIST_W-1:0] thr_stop;
  logic [DIST_W-1:0] thr_crit;
  logic              eval_on;

  // Shadow sector minima
  logic [DIST_W-1:0] min_left;
  logic [DIST_W-1:0] min_front;
  logic [DIST_W-1:0] min_right;

  out_item_t reaction_q[$];
  int        errs;
  int        n_checked;
  int        n_obst;

  // Fold one scan point into the sector it falls in
  function automatic void absorb_point(input in_item_t beat);
    int ang;
    ang = $signed(beat.point_angle);
    if (beat.point_distance != '0) begin
      if (ang >= -60 && ang < -20) begin
        if (beat.point_distance < min_left) min_left = beat.point_distance;
      end else if (ang >= -20 && ang <= 20) begin
        if (beat.point_distance < min_front) min_front = beat.point_distance;
      end else if (ang > 20 && ang <= 60) begin
        if (beat.point_distance < min_right) min_right = beat.point_distance;
      end
    end
  endfunction

  // Banded severity in per-mille, truncating division, clamped at full scale
  function automatic int unsigned severity_of(input int unsigned c);
    int unsigned w;
    int unsigned st;
    int unsigned cr;
    int unsigned s;
    w  = thr_warn;
    st = thr_stop;
    cr = thr_crit;
    if (c <= cr) s = 1000;
    else if (c <= st) s = 700 + (300 * (st - c)) / (st - cr);
    else s = 300 + (400 * (w - c)) / (w - st);
    if (s > 1000) s = 1000;
    return s;
  endfunction

  // Reaction for the scan just closed, from the current minima
  function automatic out_item_t form_reaction(input logic running);
    out_item_t   r;
    int unsigned c;
    int unsigned sev;
    r = '0;
    c = min_left;
    if (min_front < c) c = min_front;
    if (min_right < c) c = min_right;
    if (eval_on && running && c < thr_warn) begin
      sev = severity_of(c);
      if (min_front == c) begin
        r.side_code = SIDE_FRONT;
        if (c <= thr_crit) r.action_code = ACT_BACKUP;
        else if (c <= thr_stop) r.action_code = ACT_STOP;
        else r.action_code = ACT_SLOW;
      end else if (min_left < min_right) begin
        r.side_code   = SIDE_LEFT;
        r.action_code = ACT_RIGHT;
      end else begin
        r.side_code   = SIDE_RIGHT;
        r.action_code = ACT_LEFT;
      end
      if (sev >= 800) r.mood_code = MOOD_ANGRY;
      else if (sev >= 500) r.mood_code = MOOD_SUSPICIOUS;
      else r.mood_code = MOOD_NEUTRAL;
      r.obstacle_found    = 1'b1;
      r.nearest_distance  = c[DIST_W-1:0];
      r.severity_permille = sev[SEV_W-1:0];
    end
    return r;
  endfunction

  always @(posedge clk) begin
    out_item_t want;
    in_item_t  beat;
    if (rst) begin
      thr_warn  = 16'd500;
      thr_stop  = 16'd300;
      thr_crit  = 16'd150;
      eval_on   = 1'b1;
      min_left  = MIN_INIT;
      min_front = MIN_INIT;
      min_right = MIN_INIT;
      reaction_q.delete();
      errs      = 0;
      n_checked = 0;
      n_obst    = 0;
    end else begin
      // Compare a returned beat with the oldest prediction
      if (out_valid && out_ready) begin
        if (reaction_q.size() == 0) begin
          errs++;
          if (errs <= 10)
            $display("%0t: reaction beat with nothing predicted: obst=%0d dist=%0d sev=%0d",
                     $time, out_data.obstacle_found, out_data.nearest_distance,
                     out_data.severity_permille);
        end else begin
          want = reaction_q.pop_front();
          n_checked++;
          if (want.obstacle_found) n_obst++;
          if (out_data.obstacle_found !== want.obstacle_found ||
              out_data.nearest_distance !== want.nearest_distance ||
              out_data.severity_permille !== want.severity_permille ||
              out_data.action_code !== want.action_code ||
              out_data.side_code !== want.side_code ||
              out_data.mood_code !== want.mood_code) begin
            errs++;
            if (errs <= 10) begin
              $display("%0t: reaction mismatch on scan %0d", $time, n_checked);
              $display("  expected obst=%0d dist=%0d sev=%0d act=%0d side=%0d mood=%0d",
                       want.obstacle_found, want.nearest_distance, want.severity_permille,
                       want.action_code, want.side_code, want.mood_code);
              $display("  actual   obst=%0d dist=%0d sev=%0d act=%0d side=%0d mood=%0d",
                       out_data.obstacle_found, out_data.nearest_distance,
                       out_data.severity_permille, out_data.action_code,
                       out_data.side_code, out_data.mood_code);
            end
          end
        end
      end

      // Track register writes
      if (cfg_we) begin
        case (cfg_index)
          REG_WARN:     thr_warn = cfg_data;
          REG_STOP:     thr_stop = cfg_data;
          REG_CRITICAL: thr_crit = cfg_data;
          REG_ENABLE:   eval_on  = cfg_data[0];
          default: ;
        endcase
      end

      // Fold an accepted point, predict on the last one of a scan
      if (in_valid && in_ready) begin
        beat = in_data;
        absorb_point(beat);
        if (beat.last_point) begin
          reaction_q.push_back(form_reaction(beat.scanner_running));
          min_left  = MIN_INIT;
          min_front = MIN_INIT;
          min_right = MIN_INIT;
        end
      end
    end
    fail_count        <= errs;
    pending           <= reaction_q.size();
    reactions_checked <= n_checked;
    obstacles_checked <= n_obst;
  end

endmodule

// ===== tb/tb_top.sv =====
// ---------------------------------------------------------------------------
// tb_top: testbench for lidar_sector_obstacle_classifier
// Drives scan points in random bursts with a short directed opening, walks
// the thresholds through ordinary, inverted and extreme settings, stalls the
// reaction channel on its own pattern and leaves checking to the scoreboard.
// ---------------------------------------------------------------------------
module tb_top
  import lsoc_pkg::*;
();

  typedef enum int {RX_OPEN, RX_PATTERN, RX_RANDOM, RX_CHOKE} rx_mode_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = REG_WARN;
  logic [DIST_W-1:0]    cfg_data = '0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  in_item_t             in_data = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  out_item_t            out_data;

  int fail_count;
  int pending;
  int reactions_checked;
  int obstacles_checked;

  // Stimulus-side view of the thresholds, used only to aim distances
  int warn_now = 500;
  int stop_now = 300;
  int crit_now = 150;

  int burst_left = 0;
  int points_sent = 0;
  int settings_used = 1;

  rx_mode_t   rx_mode = RX_OPEN;
  int         rx_left = 0;
  logic [7:0] rx_pat = 8'hff;

  lidar_sector_obstacle_classifier u_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  lsoc_reaction_checker u_check (
    .clk               (clk),
    .rst               (rst),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_data           (in_data),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_data          (out_data),
    .fail_count        (fail_count),
    .pending           (pending),
    .reactions_checked (reactions_checked),
    .obstacles_checked (obstacles_checked)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Stall the reaction channel in modes that change every so often
  always @(posedge clk) begin
    if (rx_left == 0) begin
      rx_mode = rx_mode_t'($urandom_range(0, 3));
      rx_left = $urandom_range(20, 150);
      rx_pat  = 8'($urandom_range(1, 255));
    end
    rx_left = rx_left - 1;
    rx_pat  = {rx_pat[6:0], rx_pat[7]};
    case (rx_mode)
      RX_OPEN:    out_ready <= 1'b1;
      RX_PATTERN: out_ready <= rx_pat[0];
      RX_RANDOM:  out_ready <= ($urandom_range(0, 9) < 7);
      default:    out_ready <= (rx_left % 16 == 0);
    endcase
  end

  // Present one point, holding it until the beat is taken
  task automatic send_point(input in_item_t p);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 9) == 0) ? 60 : $urandom_range(1, 20);
    end
    in_valid <= 1'b1;
    in_data  <= p;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    burst_left--;
    points_sent++;
  endtask

  task automatic point(input int a, input int d, input bit run, input bit last);
    in_item_t p;
    p.point_angle     = a[ANG_W-1:0];
    p.point_distance  = d[DIST_W-1:0];
    p.scanner_running = run;
    p.last_point      = last;
    send_point(p);
  endtask

  // Drain: stop sending, wait out every prediction, then the fold latency
  task automatic settle();
    in_valid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic load_thresholds(input int w, input int s, input int c, input bit en);
    cfg_we    <= 1'b1;
    cfg_index <= REG_WARN;
    cfg_data  <= w[DIST_W-1:0];
    @(posedge clk);
    cfg_index <= REG_STOP;
    cfg_data  <= s[DIST_W-1:0];
    @(posedge clk);
    cfg_index <= REG_CRITICAL;
    cfg_data  <= c[DIST_W-1:0];
    @(posedge clk);
    cfg_index <= REG_ENABLE;
    cfg_data  <= {{(DIST_W-1){1'b0}}, en};
    @(posedge clk);
    cfg_we   <= 1'b0;
    warn_now = w;
    stop_now = s;
    crit_now = c;
    settings_used++;
  endtask

  task automatic random_thresholds();
    int r;
    int w;
    int s;
    int c;
    r = $urandom_range(0, 99);
    if (r < 60) begin
      c = $urandom_range(0, 1500);
      s = c + $urandom_range(1, 1500);
      w = s + $urandom_range(1, 3000);
    end else if (r < 85) begin
      w = $urandom_range(0, 3000);
      s = $urandom_range(0, 3000);
      c = $urandom_range(0, 3000);
    end else begin
      w = $urandom_range(0, 65535);
      s = $urandom_range(0, 65535);
      c = $urandom_range(0, 65535);
    end
    load_thresholds(w, s, c, $urandom_range(0, 99) < 85);
  endtask

  // Distances aimed at the band edges, with zeros, far points and full range
  function automatic int pick_range();
    int r;
    int t;
    int d;
    r = $urandom_range(0, 99);
    if (r < 8) begin
      d = 0;
    end else if (r < 40) begin
      case ($urandom_range(0, 2))
        0: t = warn_now;
        1: t = stop_now;
        default: t = crit_now;
      endcase
      d = $urandom_range(0, 8);
      d = t + d - 4;
    end else if (r < 70) begin
      d = $urandom_range(0, warn_now + warn_now / 4 + 1);
    end else if (r < 90) begin
      d = $urandom_range(0, 65535);
    end else if (r < 95) begin
      d = 65535;
    end else begin
      d = $urandom_range(0, 4);
      d = 9999 + d - 2;
    end
    if (d < 0) d = 0;
    if (d > 65535) d = 65535;
    return d;
  endfunction

  // Bearings mostly inside the sectors, some on the edges, some anywhere
  function automatic int pick_angle();
    int r;
    int a;
    int edges[8] = '{-61, -60, -21, -20, 20, 21, 60, 61};
    r = $urandom_range(0, 99);
    if (r < 10) begin
      a = edges[$urandom_range(0, 7)];
    end else if (r < 80) begin
      a = $urandom_range(0, 130);
      a = a - 65;
    end else begin
      a = $urandom_range(0, 360);
      a = a - 180;
    end
    return a;
  endfunction

  // Whole scans of random length, each closed by a last point
  task automatic run_scans(input int n_points);
    int goal;
    int len;
    goal = points_sent + n_points;
    while (points_sent < goal) begin
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
      for (int k = 0; k < len; k++)
        point(pick_angle(), pick_range(), $urandom_range(0, 9) != 0, k == len - 1);
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed scans at the reset thresholds
    // sector edges, ignored zero range, right nearer than left
    point(-60, 450, 1'b0, 1'b0);
    point(-20, 0, 1'b0, 1'b0);
    point(20, 65535, 1'b0, 1'b0);
    point(60, 320, 1'b1, 1'b1);
    // points outside every sector, left within the critical band
    point(-180, 10, 1'b0, 1'b0);
    point(180, 5, 1'b0, 1'b0);
    point(-21, 140, 1'b1, 1'b1);
    // three-way tie: front wins
    point(0, 200, 1'b0, 1'b0);
    point(-40, 200, 1'b0, 1'b0);
    point(40, 200, 1'b1, 1'b1);
    // left equals right: right is reported, severity right at angry
    point(-30, 250, 1'b0, 1'b0);
    point(30, 250, 1'b1, 1'b1);
    // exactly at the critical distance
    point(21, 150, 1'b1, 1'b1);
    // exactly at warn: no obstacle
    point(19, 500, 1'b1, 1'b1);
    // just inside warn
    point(0, 499, 1'b1, 1'b1);
    // scanner stopped
    point(0, 100, 1'b0, 1'b1);
    // empty scan
    point(90, 100, 1'b1, 1'b1);
    // just outside the sectors, front just above stop
    point(-61, 50, 1'b0, 1'b0);
    point(61, 50, 1'b0, 1'b0);
    point(-19, 301, 1'b1, 1'b1);
    // just above critical, and the suspicious boundary
    point(0, 151, 1'b1, 1'b1);
    point(0, 400, 1'b1, 1'b1);

    run_scans(200);

    settle();
    random_thresholds();
    run_scans(120);

    // Warn above the empty-sector value
    settle();
    load_thresholds(65535, 12000, 5000, 1'b1);
    run_scans(80);

    // Evaluation switched off
    settle();
    load_thresholds(500, 300, 150, 1'b0);
    run_scans(60);

    settle();
    load_thresholds(0, 0, 0, 1'b1);
    run_scans(50);

    settle();
    load_thresholds(65535, 65535, 65535, 1'b1);
    run_scans(60);

    // Stop above warn, then critical above stop
    settle();
    load_thresholds(300, 600, 100, 1'b1);
    run_scans(60);

    settle();
    load_thresholds(500, 200, 400, 1'b1);
    run_scans(60);

    repeat (3) begin
      settle();
      random_thresholds();
      run_scans(100);
    end

    settle();

    $display("Covered %0d scan points over %0d threshold settings.", points_sent,
             settings_used);
    $display("Checked %0d scan reactions, %0d of them reporting an obstacle.",
             reactions_checked, obstacles_checked);
    if (fail_count == 0 && pending == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #2000000;
    $display("FAILURE");
    $finish;
  end

endmodule
